@@ design/ocah_pkg.sv @@
// shared types, constants and hash step functions for the case-folding hash
package ocah_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned CharW = 8;

  localparam logic [CharW-1:0] UpperFirst = 8'h41;  // 'A'
  localparam logic [CharW-1:0] UpperLast  = 8'h5A;  // 'Z'
  localparam logic [CharW-1:0] CaseBit    = 8'h20;

  localparam int unsigned MixShl = 10;
  localparam int unsigned MixAsr = 6;
  localparam int unsigned FinShl1 = 3;
  localparam int unsigned FinAsr  = 11;
  localparam int unsigned FinShl2 = 15;

  typedef logic [HashW-1:0] hash_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             has_char;
    logic             is_last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  // uppercase folds to lowercase, high bytes sign-extend
  function automatic hash_t fold_char(input logic [CharW-1:0] c);
    hash_t a;
    if (c inside {[UpperFirst:UpperLast]}) begin
      a = {{(HashW-CharW){1'b0}}, c | CaseBit};
    end else if (c[CharW-1]) begin
      a = {{(HashW-CharW){1'b1}}, c};
    end else begin
      a = {{(HashW-CharW){1'b0}}, c};
    end
    return a;
  endfunction

  function automatic hash_t asr(input hash_t v, input int unsigned s);
    return hash_t'($signed(v) >>> s);
  endfunction

  function automatic hash_t mix_char(input hash_t h_in, input logic [CharW-1:0] c);
    hash_t h;
    h = h_in + fold_char(c);
    h = h + (h << MixShl);
    h = h ^ asr(h, MixAsr);
    return h;
  endfunction

  function automatic hash_t finalize(input hash_t h_in);
    hash_t h;
    h = h_in + (h_in << FinShl1);
    h = h ^ asr(h, FinAsr);
    h = h + (h << FinShl2);
    return h;
  endfunction

endpackage

@@ design/ocah_if.sv @@
// valid/ready channel interfaces for character beats and hash results
interface ocah_item_if;
  import ocah_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CharW-1:0]       char_code;
  logic                   has_char;
  logic                   is_last;

  modport source (output valid, output char_code, output has_char, output is_last,
                  input ready);
  modport sink (input valid, input char_code, input has_char, input is_last,
                output ready);
endinterface

interface ocah_hash_if;
  import ocah_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [HashW-1:0]       hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

@@ design/ocah_in_reg.sv @@
// input register stage that captures one character beat per cycle while empty or taken
module ocah_in_reg
  import ocah_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ocah_item_if.sink    item,
  input  logic         take,
  output stage_t       stage
);

  logic  valid;
  item_t data;

  assign item.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (item.ready) begin
      valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      data.char_code <= item.char_code;
      data.has_char  <= item.has_char;
      data.is_last   <= item.is_last;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = data;

endmodule

@@ design/ocah_core.sv @@
// running hash update, finalization and result register
module ocah_core
  import ocah_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  stage_t       stage,
  output logic         take,
  ocah_hash_if.source  result
);

  hash_t running_hash;
  hash_t running_hash_next;
  hash_t mixed;
  logic  res_valid;
  hash_t res_hash;

  assign take = stage.valid && (!res_valid || result.ready);

  always_comb begin
    mixed = stage.item.has_char ? mix_char(running_hash, stage.item.char_code)
                                : running_hash;
    running_hash_next = stage.item.is_last ? '0 : mixed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= '0;
      res_valid    <= 1'b0;
    end else begin
      if (take) begin
        running_hash <= running_hash_next;
      end
      if (take && stage.item.is_last) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && stage.item.is_last) begin
      res_hash <= finalize(mixed);
    end
  end

  assign result.valid      = res_valid;
  assign result.hash_value = res_hash;

endmodule

@@ design/case_folding_one_at_a_time_hash.sv @@
// top level of the case-folding one-at-a-time hash
//
//   channel  dir  payload                          beat
//   item     in   char_code[8] has_char is_last    one character or end mark
//   result   out  hash_value[32]                   one finalized hash per name
//
// one beat per cycle while the result is free or taken; a beat is registered,
// then mixed into the running hash when the core takes it, and a last beat
// loads the result register in that same cycle
// rst (synchronous) clears the running hash and both valid flags
// a waiting result holds the mix stage only, the input register keeps taking
// beats until it is itself full
module case_folding_one_at_a_time_hash
  import ocah_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  ocah_item_if.sink    item,
  ocah_hash_if.source  result
);

  stage_t stage;
  logic   take;

  // input register: parts the input handshake from the mix stage
  ocah_in_reg u_in_reg (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .take  (take),
    .stage (stage)
  );

  // mix, finalize on last beat, hold result until taken
  ocah_core u_core (
    .clk    (clk),
    .rst    (rst),
    .stage  (stage),
    .take   (take),
    .result (result)
  );

endmodule
